// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/lpr_pkg.sv -----
package lpr_pkg;

  localparam int COORD_BITS = 12;
  localparam int SPAN_W     = COORD_BITS + 1;
  localparam int COLOR_BITS = 24;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic                         opcode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic        [COLOR_BITS-1:0] line_color;
  } item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic        [COLOR_BITS-1:0] pixel_color;
    logic                         last_pixel;
  } pixel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } lpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } lpr_stat_t;

endpackage

// ----- src/lpr_ctrl.sv -----
`include "assert_macros.svh"

module lpr_ctrl import lpr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  logic      opcode,
  output logic      pixel_valid,
  input  logic      pixel_ready,
  output lpr_cmd_t  cmd,
  input  lpr_stat_t stat
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DRAW = 1'b1;

  logic state;
  logic state_next;
  logic pixel_valid_next;
  logic accept;

  assign item_ready = !pixel_valid || pixel_ready;
  assign accept     = item_valid && item_ready;
  assign cmd.load   = accept && (opcode == OP_LOAD);
  assign cmd.step   = accept && (opcode == OP_STEP) && (state == ST_DRAW);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_DRAW;
      end
      ST_DRAW: begin
        if (cmd.step && stat.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pixel_valid_next = pixel_valid;
    if (cmd.step) begin
      pixel_valid_next = 1'b1;
    end else if (pixel_ready) begin
      pixel_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pixel_valid <= 1'b0;
    end else begin
      state       <= state_next;
      pixel_valid <= pixel_valid_next;
    end
  end

  `ASSERT_IMP(a_step_only_drawing, clk, rst, cmd.step, state == ST_DRAW)
  `ASSERT_NEXT(a_last_ends_line, clk, rst, cmd.step && stat.last, state == ST_IDLE)
  `ASSERT_IMP(a_valid_from_step, clk, rst, $rose(pixel_valid), $past(cmd.step))

endmodule

// ----- src/lpr_datapath.sv -----
`include "assert_macros.svh"

module lpr_datapath import lpr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  item_t     item,
  input  lpr_cmd_t  cmd,
  output lpr_stat_t stat,
  output pixel_t    pixel
);

  logic                  major_is_y;
  logic [COORD_BITS-1:0] base_minor;
  logic [COORD_BITS-1:0] major_end;
  logic [COORD_BITS-1:0] major_now;
  logic [SPAN_W-1:0]     major_span;
  logic [SPAN_W-1:0]     minor_abs;
  logic                  minor_neg;
  logic [SPAN_W-1:0]     quot;
  logic [SPAN_W-1:0]     rem;
  logic [COLOR_BITS-1:0] held_color;

  // Load setup.
  logic signed [SPAN_W-1:0] dx;
  logic signed [SPAN_W-1:0] dy;
  logic [SPAN_W-1:0]        adx;
  logic [SPAN_W-1:0]        ady;
  logic                     sel_y;
  logic [COORD_BITS-1:0]    bmaj;
  logic [COORD_BITS-1:0]    bmin;
  logic [COORD_BITS-1:0]    emaj;
  logic [COORD_BITS-1:0]    emin;
  logic [SPAN_W-1:0]        mspan;
  logic [SPAN_W-1:0]        nspan;

  // Step arithmetic.
  logic [SPAN_W-1:0]     minor_full;
  logic [COORD_BITS-1:0] minor;
  logic [SPAN_W:0]       rsum;
  logic                  wrap;

  always_comb begin
    dx  = SPAN_W'(item.end_x) - SPAN_W'(item.start_x);
    dy  = SPAN_W'(item.end_y) - SPAN_W'(item.start_y);
    adx = dx[SPAN_W-1] ? -dx : dx;
    ady = dy[SPAN_W-1] ? -dy : dy;
    sel_y = 1'b1;
    bmaj  = item.start_y;
    bmin  = item.start_x;
    emaj  = item.end_y;
    emin  = item.end_x;
    if (item.start_x <= item.end_x && adx >= ady) begin
      sel_y = 1'b0;
      bmaj  = item.start_x;
      bmin  = item.start_y;
      emaj  = item.end_x;
      emin  = item.end_y;
    end else if (item.end_x <= item.start_x && adx >= ady) begin
      sel_y = 1'b0;
      bmaj  = item.end_x;
      bmin  = item.end_y;
      emaj  = item.start_x;
      emin  = item.start_y;
    end else if (item.end_y <= item.start_y) begin
      bmaj = item.end_y;
      bmin = item.end_x;
      emaj = item.start_y;
      emin = item.start_x;
    end
    mspan = SPAN_W'($signed(emaj)) - SPAN_W'($signed(bmaj));
    nspan = SPAN_W'($signed(emin)) - SPAN_W'($signed(bmin));
  end

  always_comb begin
    minor_full = minor_neg ? (SPAN_W'($signed(base_minor)) - quot)
                           : (SPAN_W'($signed(base_minor)) + quot);
    minor = minor_full[COORD_BITS-1:0];
    stat.last = $signed(major_now) >= $signed(major_end);
    rsum = {1'b0, rem} + {1'b0, minor_abs};
    wrap = (major_span != '0) && (rsum >= {1'b0, major_span});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      major_span <= '0;
      rem        <= '0;
    end else if (cmd.load) begin
      major_span <= mspan;
      rem        <= '0;
    end else if (cmd.step) begin
      rem <= wrap ? SPAN_W'(rsum - {1'b0, major_span}) : rsum[SPAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      major_is_y <= sel_y;
      base_minor <= bmin;
      major_end  <= emaj;
      major_now  <= bmaj;
      minor_neg  <= nspan[SPAN_W-1];
      minor_abs  <= nspan[SPAN_W-1] ? -nspan : nspan;
      quot       <= '0;
      held_color <= item.line_color;
    end else if (cmd.step) begin
      if (!stat.last) major_now <= major_now + 1'b1;
      if (wrap) quot <= quot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pixel.pixel_x     <= major_is_y ? minor : major_now;
      pixel.pixel_y     <= major_is_y ? major_now : minor;
      pixel.pixel_color <= held_color;
      pixel.last_pixel  <= stat.last;
    end
  end

  `ASSERT_IMP(a_rem_below_span, clk, rst, major_span != '0, rem < major_span)

endmodule

// ----- src/line_pixel_rasterizer_core.sv -----
// Line rasterizer: walks a straight line one pixel per step beat.
// Input channel (item_valid/item_ready/item): a beat with opcode load latches
// two endpoints and a color and produces no pixel; it replaces any line in
// progress. A beat with opcode step emits the next pixel of the loaded line,
// or nothing when no line is active.
// Output channel (pixel_valid/pixel_ready/pixel): one beat per pixel, with
// the final pixel of a line flagged by last_pixel.
// A step beat's pixel is registered in the output register. Throughput: one item per
// cycle while item_ready is high; the minor coordinate comes from a quotient
// and remainder accumulator that takes one add and compare per pixel.
// Reset clears the controller to idle with no line loaded and no pixel held.
// When the receiver stalls, the pixel waits in the output register and
// item_ready drops until it is taken; item_ready is high whenever the
// output register is empty or being drained in the same cycle.
module line_pixel_rasterizer_core import lpr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  item_t  item,
  output logic   pixel_valid,
  input  logic   pixel_ready,
  output pixel_t pixel
);

  // Command and status between the controller and the datapath.
  lpr_cmd_t  cmd;
  lpr_stat_t stat;

  // The controller owns the handshake, the drawing state and the output valid.
  lpr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .opcode      (item.opcode),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  // The datapath holds the line setup, the accumulator and the pixel register.
  lpr_datapath u_datapath (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cmd   (cmd),
    .stat  (stat),
    .pixel (pixel)
  );

endmodule

// ----- tb/line_pixel_rasterizer_core_tb.sv -----
// Self-checking bench for the line rasterizer core.
//
// A stimulus list of load and step beats is built once at time zero. A clocked
// driver plays it into the input channel in bursts separated by random gaps.
// A clocked monitor watches both channels. Every accepted input beat runs
// through a behavioral copy of the rasterizer. Every pixel that copy predicts
// is queued, and each pixel beat that leaves the core is compared with the
// oldest queued pixel, field by field. The receiver stalls in phases of varying
// intensity. Twice it also holds off for a long stretch, so that the output
// register fills and item_ready has to drop while the driver keeps offering.
module line_pixel_rasterizer_core_tb;
  import lpr_pkg::*;

  localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
  localparam int ITEM_BITS   = $bits(item_t);
  localparam int RANDOM_BEATS = 1650;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PRINT_CAP   = 40;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   item_valid = 1'b0;
  logic   item_ready;
  item_t  item = '0;
  logic   pixel_valid;
  logic   pixel_ready = 1'b0;
  pixel_t pixel;

  line_pixel_rasterizer_core u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Beats waiting to be driven, and pixels the core still owes us.
  item_t  pending_items[$];
  pixel_t expected_pixels[$];

  // Run statistics and the error tally.
  int cycle_count = 0;
  int error_count = 0;
  int counted_beats = 0;
  int ignored_beats = 0;
  int lines_loaded = 0;
  int pixels_checked = 0;
  int idle_steps_seen = 0;
  int input_stalls = 0;
  int long_holds = 0;

  // Behavioral copy of the rasterizer state. Coordinates are kept as plain
  // integers; they are truncated to the port width only when a pixel is built.
  bit          ln_active;
  bit          ln_y_major;
  int          ln_base_major;
  int          ln_base_minor;
  int          ln_major_end;
  int          ln_major_now;
  int          ln_major_span;
  int          ln_minor_span;
  logic [23:0] ln_color;

  function automatic void clear_raster();
    ln_active     = 1'b0;
    ln_y_major    = 1'b0;
    ln_base_major = 0;
    ln_base_minor = 0;
    ln_major_end  = 0;
    ln_major_now  = 0;
    ln_major_span = 0;
    ln_minor_span = 0;
    ln_color      = '0;
  endfunction

  function automatic void start_walk(bit y_major, int bmaj, int bmin, int emaj, int emin);
    ln_y_major    = y_major;
    ln_base_major = bmaj;
    ln_base_minor = bmin;
    ln_major_end  = emaj;
    ln_major_now  = bmaj;
    ln_major_span = emaj - bmaj;
    ln_minor_span = emin - bmin;
  endfunction

  // Applies one accepted beat to the behavioral state and says whether a pixel
  // comes out of it, and which one.
  function automatic void rasterize_beat(input item_t it, output bit emits,
                                         output pixel_t px);
    int x1, y1, x2, y2, adx, ady, minor, quot, mag;
    bit last;
    emits = 1'b0;
    px    = '0;
    if (it.opcode == OP_LOAD) begin
      x1  = $signed(it.start_x);
      y1  = $signed(it.start_y);
      x2  = $signed(it.end_x);
      y2  = $signed(it.end_y);
      adx = (x2 >= x1) ? x2 - x1 : x1 - x2;
      ady = (y2 >= y1) ? y2 - y1 : y1 - y2;
      // The four octant cases are tried in a fixed order and the first match
      // wins, so an exact diagonal always walks along x.
      if (x1 <= x2 && adx >= ady) start_walk(1'b0, x1, y1, x2, y2);
      else if (x2 <= x1 && adx >= ady) start_walk(1'b0, x2, y2, x1, y1);
      else if (y2 <= y1 && ady >= adx) start_walk(1'b1, y2, x2, y1, x1);
      else start_walk(1'b1, y1, x1, y2, x2);
      ln_color  = it.line_color;
      ln_active = 1'b1;
    end else if (ln_active) begin
      minor = ln_base_minor;
      last  = (ln_major_now >= ln_major_end);
      // A point-sized line has no major span and never divides.
      if (ln_major_span > 0) begin
        mag   = (ln_minor_span < 0) ? -ln_minor_span : ln_minor_span;
        quot  = (mag * (ln_major_now - ln_base_major)) / ln_major_span;
        minor = (ln_minor_span < 0) ? ln_base_minor - quot : ln_base_minor + quot;
      end
      if (ln_y_major) begin
        px.pixel_x = COORD_BITS'(minor);
        px.pixel_y = COORD_BITS'(ln_major_now);
      end else begin
        px.pixel_x = COORD_BITS'(ln_major_now);
        px.pixel_y = COORD_BITS'(minor);
      end
      px.pixel_color = ln_color;
      px.last_pixel  = last;
      emits = 1'b1;
      if (last) ln_active = 1'b0;
      else ln_major_now = ln_major_now + 1;
    end
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("[cycle %0d] mismatch: %s", cycle_count, msg);
  endtask

  task automatic check_pixel(pixel_t got);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("pixel beat with nothing pending: %p", got));
      return;
    end
    want = expected_pixels.pop_front();
    pixels_checked++;
    if (got.pixel_x !== want.pixel_x)
      report_mismatch($sformatf("pixel_x %0d, predicted %0d", got.pixel_x, want.pixel_x));
    if (got.pixel_y !== want.pixel_y)
      report_mismatch($sformatf("pixel_y %0d, predicted %0d", got.pixel_y, want.pixel_y));
    if (got.pixel_color !== want.pixel_color)
      report_mismatch($sformatf("pixel_color %06h, predicted %06h",
                                got.pixel_color, want.pixel_color));
    if (got.last_pixel !== want.last_pixel)
      report_mismatch($sformatf("last_pixel %b, predicted %b",
                                got.last_pixel, want.last_pixel));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  function automatic int rand_coord();
    return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
  endfunction

  // Offsets a coordinate, mirroring the offset when it would leave the range.
  // The distance is kept, which matters for exact diagonals.
  function automatic int near(int origin, int offset);
    int v;
    v = origin + offset;
    if (v > COORD_MAX || v < COORD_MIN) v = origin - offset;
    return v;
  endfunction

  function automatic int signed_offset(int reach);
    return int'($urandom_range(2 * reach)) - reach;
  endfunction

  function automatic void push_load(int x1, int y1, int x2, int y2, logic [23:0] color);
    item_t it;
    it.opcode     = OP_LOAD;
    it.start_x    = COORD_BITS'(x1);
    it.start_y    = COORD_BITS'(y1);
    it.end_x      = COORD_BITS'(x2);
    it.end_y      = COORD_BITS'(y2);
    it.line_color = color;
    pending_items.push_back(it);
    counted_beats++;
  endfunction

  // Step beats carry random endpoint and color fields, which the core must
  // ignore. Steps that are known to find no active line are not counted.
  function automatic void push_steps(int n, bit counted);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it            = item_t'(ITEM_BITS'({$urandom, $urandom, $urandom}));
      it.opcode     = OP_STEP;
      pending_items.push_back(it);
      if (counted) counted_beats++;
      else ignored_beats++;
    end
  endfunction

  // One random line: a load followed, in most cases, by a complete walk.
  // Some walks are cut short so the next load replaces a line in progress,
  // and some run past the end to probe stepping with no active line.
  function automatic void add_random_line();
    int x1, y1, x2, y2, d, span, walk, kind, tail;
    logic [23:0] color;
    kind  = $urandom_range(99);
    color = 24'($urandom);
    x1    = rand_coord();
    y1    = rand_coord();
    if (kind < 65) begin
      x2 = near(x1, signed_offset(15));
      y2 = near(y1, signed_offset(15));
    end else if (kind < 80) begin
      x2 = near(x1, signed_offset(150));
      y2 = near(y1, signed_offset(150));
    end else if (kind < 90) begin
      // Degenerate shapes, often anchored on the edge of the coordinate range.
      if ($urandom_range(1)) x1 = $urandom_range(1) ? COORD_MAX : COORD_MIN;
      if ($urandom_range(1)) y1 = $urandom_range(1) ? COORD_MAX : COORD_MIN;
      d = $urandom_range(1, 20);
      case ($urandom_range(3))
        0: begin
          x2 = x1;
          y2 = y1;
        end
        1: begin
          x2 = near(x1, $urandom_range(1) ? d : -d);
          y2 = near(y1, $urandom_range(1) ? d : -d);
        end
        2: begin
          x2 = near(x1, $urandom_range(1) ? d : -d);
          y2 = y1;
        end
        default: begin
          x2 = x1;
          y2 = near(y1, $urandom_range(1) ? d : -d);
        end
      endcase
    end else begin
      x2 = rand_coord();
      y2 = rand_coord();
    end
    span = (x2 >= x1) ? x2 - x1 : x1 - x2;
    d    = (y2 >= y1) ? y2 - y1 : y1 - y2;
    if (d > span) span = d;
    push_load(x1, y1, x2, y2, color);
    tail = 0;
    if (kind >= 90) begin
      // Long lines are only walked partway; the next load replaces them.
      walk = $urandom_range(1, 40);
      if (walk > span + 1) walk = span + 1;
    end else begin
      walk = span + 1;
      case ($urandom_range(9))
        0: walk = $urandom_range(span);
        1: tail = $urandom_range(1, 3);
        default: ;
      endcase
    end
    push_steps(walk, 1'b1);
    push_steps(tail, 1'b0);
  endfunction

  // Directed opening: a step with nothing loaded, point lines at both corners
  // and both color extremes, a diagonal in each direction, a steep line each
  // way, and a line replaced while it is being walked.
  function automatic void add_directed();
    push_steps(1, 1'b0);
    push_load(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 24'h000000);
    push_steps(1, 1'b1);
    push_steps(1, 1'b0);
    push_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'hFFFFFF);
    push_steps(1, 1'b1);
    push_load(-1, -1, 1, 1, 24'h123456);
    push_steps(3, 1'b1);
    push_load(COORD_MAX, 0, COORD_MAX - 2, -2, 24'hA5A5A5);
    push_steps(3, 1'b1);
    push_load(0, 5, 1, 2, 24'h5A5A5A);
    push_steps(4, 1'b1);
    push_load(COORD_MIN, COORD_MAX - 3, COORD_MIN + 2, COORD_MAX, 24'h0F0F0F);
    push_steps(2, 1'b1);
    push_load(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 24'hF0F0F0);
    push_steps(3, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: plays pending_items into the input channel. A beat stays on the
  // bus, unchanged, until the core accepts it. Between bursts of random
  // length, valid drops for a random gap; about a quarter of the bursts
  // follow the previous one back to back.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        item_valid <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end else begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: works in phases of random length, each with its own stall
  // rate, from never stalling to stalling most of the time. At two fixed
  // points it holds off entirely, with pixel_ready low. The driver keeps
  // offering beats meanwhile, so the core's output register fills and the
  // input side has to stall.
  // ---------------------------------------------------------------------------
  int rx_cycles = 0;
  int rx_phase_left = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      pixel_ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == 1500 || rx_cycles == 4000) begin
        rx_hold_left = 300;
        long_holds++;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pixel_ready <= 1'b0;
      end else begin
        if (rx_phase_left == 0) begin
          rx_phase_left = $urandom_range(20, 200);
          case ($urandom_range(4))
            0, 1: rx_stall_pct = 0;
            2: rx_stall_pct = 30;
            3: rx_stall_pct = 60;
            default: rx_stall_pct = 90;
          endcase
        end
        rx_phase_left--;
        pixel_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks the outgoing pixel first, then applies the incoming beat
  // to the behavioral model. A step accepted at one edge cannot have its
  // pixel accepted at the same edge, so doing both here keeps the order fixed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit     emits;
    pixel_t px;
    cycle_count++;
    if (rst) begin
      clear_raster();
    end else begin
      if (pixel_valid && pixel_ready) check_pixel(pixel);
      if (item_valid && item_ready) begin
        rasterize_beat(item, emits, px);
        if (emits) expected_pixels.push_back(px);
        if (item.opcode == OP_LOAD) lines_loaded++;
        else if (!emits) idle_steps_seen++;
      end
      if (item_valid && !item_ready) input_stalls++;
    end
  end

  // Watchdog on the total run length.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("line_pixel_rasterizer_core_tb NOT OK");
    $finish;
  end

  // Main sequence: build the stimulus, release reset, wait for the core to
  // drain, then give the verdict. The drain test runs on the falling edge so
  // that it sees the queues and the bus after the rising edge has settled.
  initial begin
    add_directed();
    counted_beats = 0;
    while (counted_beats < RANDOM_BEATS) add_random_line();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_items.size() != 0 || item_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d predicted pixels never arrived", expected_pixels.size()));
    $display("Drove %0d line loads and %0d step beats in %0d cycles; %0d steps found no line.",
             lines_loaded, pixels_checked + idle_steps_seen, cycle_count, idle_steps_seen);
    $display("Checked %0d pixels; input stalled %0d cycles, with %0d long receiver holds.",
             pixels_checked, input_stalls, long_holds);
    if (error_count == 0) begin
      $display("line_pixel_rasterizer_core_tb OK");
    end else begin
      $display("line_pixel_rasterizer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
